// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CES_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CES_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- rtl/ces_pkg.sv -----
`timescale 1ns / 1ps
package ces_pkg;
  localparam int QueueDepth = 16;
  localparam int KindCount  = 16;
  localparam int MaxResults = 16;
  localparam int SlotW      = $clog2(QueueDepth);

  localparam logic [2:0] OP_SCHED_DELAY = 3'd0;
  localparam logic [2:0] OP_SCHED_WIN   = 3'd1;
  localparam logic [2:0] OP_ADVANCE     = 3'd2;
  localparam logic [2:0] OP_FIRE_NEXT   = 3'd3;
  localparam logic [2:0] OP_UNSCHED     = 3'd4;
  localparam logic [2:0] OP_ELAPSED     = 3'd5;

  localparam logic [1:0] REC_FIRED   = 2'd0;
  localparam logic [1:0] REC_UNSCHED = 2'd1;
  localparam logic [1:0] REC_ELAPSED = 2'd2;
  localparam logic [1:0] REC_ERROR   = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_COUNT = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_EMPTY = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] queued_at;
    logic [63:0] due_at;
  } slot_t;

  typedef struct packed {
    logic        we;
    logic [SlotW-1:0] waddr;
    slot_t       wdata;
    logic        re;
    logic [SlotW-1:0] raddr;
  } mem_req_t;

  function automatic logic [31:0] sat32(input logic [63:0] d);
    logic [31:0] r;
    if (d[63]) begin
      r = (d < 64'hFFFF_FFFF_8000_0000) ? 32'h8000_0000 : d[31:0];
    end else begin
      r = (d > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : d[31:0];
    end
    return r;
  endfunction
endpackage

// ----- rtl/cycle_event_scheduler.sv -----
`timescale 1ns / 1ps
// Schedule writes its slot on accept and gives no result; errors are registered on accept.
// Lookups: scan (one slot read at a time), decide, read when found, then out.
// Advance / fire next: scan then decide, repeated; record n leaves after scan n+1 tells if it
// is last, so each fired item leaves after the scan that follows its own, unless stalled.
// Throughput: one item in flight; next item accepted once the last result leaves.
// Reset (rst_n low, synchronous): clock cleared, all slots invalid; slot RAM needs no clearing.
`include "assert_macros.svh"
module cycle_event_scheduler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic [3:0]         in_event_kind,
  input  logic signed [31:0] in_tick_count,
  input  logic signed [31:0] in_start_offset,
  input  logic [31:0]        in_window_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_record_kind,
  output logic [3:0]         out_event_id,
  output logic signed [31:0] out_cycle_value,
  output logic               out_found,
  output logic [1:0]         out_error_code,
  output logic               out_last
);
  ces_pkg::mem_req_t mreq;
  ces_pkg::slot_t    rdata;
  logic              busy;

  // slot table: kind, queued and due cycles per slot; valid bits live in ctrl
  ces_slot_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));

  ces_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_event_kind(in_event_kind), .in_tick_count(in_tick_count),
    .in_start_offset(in_start_offset), .in_window_length(in_window_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_record_kind(out_record_kind), .out_event_id(out_event_id),
    .out_cycle_value(out_cycle_value), .out_found(out_found),
    .out_error_code(out_error_code), .out_last(out_last),
    .mreq(mreq), .rdata(rdata), .busy(busy)
  );

  // No item accepted while a lookup or emission is running.
  `CES_ASSERT_IMP(a_no_accept_busy, busy, in_stall)
  // Never write and read the RAM in the same cycle.
  `CES_ASSERT_IMP(a_mem_excl, mreq.we, !mreq.re)
  // Fired records never carry an error code.
  `CES_ASSERT_IMP(a_fired_clean, out_valid && out_record_kind == ces_pkg::REC_FIRED,
                  out_error_code == ces_pkg::ERR_NONE)
endmodule

// ----- rtl/ces_slot_ram.sv -----
`timescale 1ns / 1ps
module ces_slot_ram (
  input  logic                 clk,
  input  ces_pkg::mem_req_t    req,
  output ces_pkg::slot_t       rdata
);
  ces_pkg::slot_t mem [ces_pkg::QueueDepth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// ----- rtl/ces_ctrl.sv -----
`timescale 1ns / 1ps
module ces_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_op,
  input  logic [3:0]          in_event_kind,
  input  logic signed [31:0]  in_tick_count,
  input  logic signed [31:0]  in_start_offset,
  input  logic [31:0]         in_window_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_record_kind,
  output logic [3:0]          out_event_id,
  output logic signed [31:0]  out_cycle_value,
  output logic                out_found,
  output logic [1:0]          out_error_code,
  output logic                out_last,
  output ces_pkg::mem_req_t   mreq,
  input  ces_pkg::slot_t      rdata,
  output logic                busy
);
  localparam int SW = ces_pkg::SlotW;
  localparam logic [SW:0] DEPTH = (SW+1)'(ces_pkg::QueueDepth);
  localparam logic [4:0] MAXR = 5'(ces_pkg::MaxResults);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] now_r, now_nxt;
  logic [ces_pkg::QueueDepth-1:0] vld_r, vld_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [SW:0] idx_r, idx_nxt;
  logic        rdv_r, rdv_nxt;
  logic [SW-1:0] ridx_r, ridx_nxt;
  logic        best_v_r, best_v_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [63:0] bdue_r, bdue_nxt;
  logic [3:0]  bkind_r, bkind_nxt;
  logic [4:0]  nout_r, nout_nxt;
  logic [3:0]  hk_r, hk_nxt;
  logic [31:0] hcv_r, hcv_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ork_r, ork_nxt;
  logic [3:0]  oid_r, oid_nxt;
  logic [31:0] ocv_r, ocv_nxt;
  logic        ofd_r, ofd_nxt;
  logic [1:0]  oer_r, oer_nxt;
  logic        ols_r, ols_nxt;
  logic [63:0] tick64, off64, qat;
  logic [63:0] cmp_now;
  logic        fire_ok;
  logic        better;
  logic        free_v;
  logic [SW-1:0] free_i;

  assign tick64 = {{32{in_tick_count[31]}}, in_tick_count};
  assign off64  = {{32{in_start_offset[31]}}, in_start_offset};
  assign qat    = now_r + off64;

  // fire next compares against the earliest due cycle on its first scan
  assign cmp_now = (op_r == ces_pkg::OP_FIRE_NEXT && nout_r == '0) ? bdue_r : now_r;
  assign fire_ok = best_v_r && (bdue_r <= cmp_now) && (nout_r < MAXR);

  always_comb begin
    free_v = 1'b0;
    free_i = '0;
    for (int i = ces_pkg::QueueDepth - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_v = 1'b1;
        free_i = SW'(i);
      end
    end
  end

  always_comb begin
    if (op_r == ces_pkg::OP_UNSCHED || op_r == ces_pkg::OP_ELAPSED) begin
      better = (rdata.kind == kind_r) && (!best_v_r || rdata.due_at < bdue_r);
    end else begin
      better = !best_v_r || rdata.due_at < bdue_r ||
               (rdata.due_at == bdue_r && rdata.kind < bkind_r);
    end
  end

  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign busy     = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_record_kind = ork_r;
  assign out_event_id = oid_r;
  assign out_cycle_value = ocv_r;
  assign out_found = ofd_r;
  assign out_error_code = oer_r;
  assign out_last = ols_r;

  always_comb begin
    st_nxt = st_r; now_nxt = now_r; vld_nxt = vld_r; op_nxt = op_r;
    kind_nxt = kind_r; idx_nxt = idx_r; rdv_nxt = 1'b0; ridx_nxt = ridx_r;
    best_v_nxt = best_v_r; best_nxt = best_r; bdue_nxt = bdue_r;
    bkind_nxt = bkind_r; nout_nxt = nout_r; hk_nxt = hk_r; hcv_nxt = hcv_r;
    ov_nxt = ov_r; ork_nxt = ork_r; oid_nxt = oid_r; ocv_nxt = ocv_r;
    ofd_nxt = ofd_r; oer_nxt = oer_r; ols_nxt = ols_r;
    mreq = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_nxt = in_op; kind_nxt = in_event_kind; nout_nxt = '0;
          idx_nxt = '0; best_v_nxt = 1'b0;
          ork_nxt = ces_pkg::REC_ERROR; oid_nxt = in_event_kind; ocv_nxt = '0;
          ofd_nxt = 1'b0; ols_nxt = 1'b1;
          case (in_op)
            ces_pkg::OP_SCHED_DELAY, ces_pkg::OP_SCHED_WIN: begin
              if ((in_op == ces_pkg::OP_SCHED_DELAY && in_tick_count < 0) ||
                  32'(in_event_kind) >= 32'(ces_pkg::KindCount)) begin
                ov_nxt = 1'b1; oer_nxt = ces_pkg::ERR_COUNT;
              end else if (!free_v) begin
                ov_nxt = 1'b1; oer_nxt = ces_pkg::ERR_FULL;
              end else begin
                vld_nxt[free_i] = 1'b1;
                mreq.we = 1'b1; mreq.waddr = free_i;
                mreq.wdata.kind = in_event_kind;
                if (in_op == ces_pkg::OP_SCHED_DELAY) begin
                  mreq.wdata.queued_at = now_r;
                  mreq.wdata.due_at = now_r + tick64;
                end else begin
                  mreq.wdata.queued_at = qat;
                  mreq.wdata.due_at = qat + {32'd0, in_window_length};
                end
              end
            end
            ces_pkg::OP_ADVANCE: begin
              if (in_tick_count <= 0) begin
                ov_nxt = 1'b1; oer_nxt = ces_pkg::ERR_COUNT;
              end else begin
                now_nxt = now_r + tick64;
                st_nxt = S_SCAN;
              end
            end
            ces_pkg::OP_FIRE_NEXT: begin
              if (vld_r == '0) begin
                ov_nxt = 1'b1; oer_nxt = ces_pkg::ERR_EMPTY;
              end else begin
                st_nxt = S_SCAN;
              end
            end
            ces_pkg::OP_UNSCHED, ces_pkg::OP_ELAPSED: begin
              st_nxt = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // one slot read per cycle, compare on returning data
        if (rdv_r && vld_r[ridx_r] && better) begin
          best_v_nxt = 1'b1; best_nxt = ridx_r;
          bdue_nxt = rdata.due_at; bkind_nxt = rdata.kind;
        end
        if (idx_r < DEPTH) begin
          mreq.re = 1'b1; mreq.raddr = idx_r[SW-1:0];
          rdv_nxt = 1'b1; ridx_nxt = idx_r[SW-1:0];
          idx_nxt = idx_r + 1'b1;
        end else if (!rdv_r) begin
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (op_r)
          ces_pkg::OP_UNSCHED, ces_pkg::OP_ELAPSED: begin
            ork_nxt = (op_r == ces_pkg::OP_UNSCHED) ? ces_pkg::REC_UNSCHED
                                                  : ces_pkg::REC_ELAPSED;
            oid_nxt = kind_r; ols_nxt = 1'b1;
            ofd_nxt = 1'b0; oer_nxt = ces_pkg::ERR_NONE; ocv_nxt = '0;
            if (best_v_r && 32'(kind_r) < 32'(ces_pkg::KindCount)) begin
              mreq.re = 1'b1; mreq.raddr = best_r;
              st_nxt = S_RD;
            end else begin
              st_nxt = S_OUT;
            end
          end
          default: begin
            // a fired record is held until the next scan shows whether it is
            // last; it leaves once the output register is free
            if (nout_r != '0 && ov_r && out_stall) begin
              st_nxt = S_DEC;
            end else begin
              if (op_r == ces_pkg::OP_FIRE_NEXT && nout_r == '0) begin
                now_nxt = bdue_r;
              end
              if (nout_r != '0) begin
                ov_nxt = 1'b1;
                ork_nxt = ces_pkg::REC_FIRED; oid_nxt = hk_r; ocv_nxt = hcv_r;
                ofd_nxt = 1'b0; oer_nxt = ces_pkg::ERR_NONE;
                ols_nxt = !fire_ok;
              end
              if (fire_ok) begin
                vld_nxt[best_r] = 1'b0;
                hk_nxt = bkind_r;
                hcv_nxt = ces_pkg::sat32(cmp_now - bdue_r);
                nout_nxt = nout_r + 1'b1;
                idx_nxt = '0; best_v_nxt = 1'b0; st_nxt = S_SCAN;
              end else begin
                st_nxt = S_IDLE;
              end
            end
          end
        endcase
      end
      S_RD: begin
        if (op_r == ces_pkg::OP_UNSCHED) begin
          vld_nxt[best_r] = 1'b0;
          ocv_nxt = ces_pkg::sat32(rdata.due_at - now_r);
        end else begin
          ocv_nxt = ces_pkg::sat32(now_r - rdata.queued_at);
        end
        ofd_nxt = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; now_r <= '0; vld_r <= '0; ov_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; now_r <= now_nxt; vld_r <= vld_nxt; ov_r <= ov_nxt;
      rdv_r <= rdv_nxt;
    end
    op_r <= op_nxt; kind_r <= kind_nxt; idx_r <= idx_nxt; ridx_r <= ridx_nxt;
    best_v_r <= best_v_nxt; best_r <= best_nxt; bdue_r <= bdue_nxt;
    bkind_r <= bkind_nxt; nout_r <= nout_nxt; hk_r <= hk_nxt; hcv_r <= hcv_nxt;
    ork_r <= ork_nxt; oid_r <= oid_nxt; ocv_r <= ocv_nxt; ofd_r <= ofd_nxt;
    oer_r <= oer_nxt; ols_r <= ols_nxt;
  end
endmodule
